### sv/bgrgba_pkg.sv
// Shared types and constants for the GRBG Bayer 2x2 binning to RGBA block.
`default_nettype none
package bgrgba_pkg;

  // Field and register widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned PAIR_W  = 2 * BYTE_W;
  localparam int unsigned CIDX_W  = 1;

  // Size limits and reset values of the configuration registers.
  localparam int unsigned DEF_MAX_OUT_WIDTH = 2048;
  localparam int unsigned MAX_OUT_HEIGHT    = 2048;
  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 12'd480;

  // Alpha is constant and fully opaque.
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_OUT_WIDTH  = 1'b0,
    REG_OUT_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-item decisions handed from the position control to the datapath.
  typedef struct packed {
    logic store_wr;   // odd column of an even row: write a byte pair
    logic pix_req;    // odd column of an odd row: read a pair and emit a pixel
    logic frame_end;  // this item closes the frame
  } item_ctrl_t;

endpackage
`default_nettype wire

### sv/bayer_grbg_binning_to_rgba.sv
// Top level: GRBG Bayer byte stream binned 2x2 into RGBA pixels.
// Throughput: one raw byte per clock cycle, sustained, while the output is not stalled.
// A pixel's last (odd-column, odd-row) byte passes through the registered line store read,
// which runs beside the first stage, and then through the output register.
// Reset clears the size registers to 640 by 480, the raster counters and the held byte;
// the line store is not cleared, as every entry is written on an even row before it is read.
`default_nettype none
module bayer_grbg_binning_to_rgba #(
  parameter int unsigned MAX_OUT_WIDTH = bgrgba_pkg::DEF_MAX_OUT_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bgrgba_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  wire logic [bgrgba_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [bgrgba_pkg::BYTE_W-1:0]    raw_byte_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [bgrgba_pkg::BYTE_W-1:0]         red_o,
  output logic [bgrgba_pkg::BYTE_W-1:0]         green_o,
  output logic [bgrgba_pkg::BYTE_W-1:0]         blue_o,
  output logic [bgrgba_pkg::BYTE_W-1:0]         alpha_o,
  output logic                                  frame_end_o
);

  localparam int unsigned ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  bgrgba_pkg::item_ctrl_t          item_ctrl;
  logic                            accept;
  logic [ADDR_W-1:0]               lb_addr;
  logic [bgrgba_pkg::PAIR_W-1:0]   lb_wr_data;
  logic [bgrgba_pkg::PAIR_W-1:0]   lb_rd_data;
  logic [bgrgba_pkg::BYTE_W-1:0]   held_byte;

  assign accept = in_valid_i && !in_stall_o;

  // Raster position and configuration.
  bgrgba_ctrl #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .raw_byte_i (raw_byte_i),
    .ctrl_o     (item_ctrl),
    .addr_o     (lb_addr),
    .wr_data_o  (lb_wr_data),
    .held_o     (held_byte)
  );

  // Even row line store.
  bgrgba_line_buf #(
    .DEPTH  (MAX_OUT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_line_buf (
    .clk_i     (clk_i),
    .we_i      (item_ctrl.store_wr),
    .re_i      (item_ctrl.pix_req),
    .addr_i    (lb_addr),
    .wr_data_i (lb_wr_data),
    .rd_data_o (lb_rd_data)
  );

  // Pixel assembly and output handshake.
  bgrgba_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (item_ctrl),
    .raw_byte_i  (raw_byte_i),
    .held_i      (held_byte),
    .pair_i      (lb_rd_data),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .frame_end_o (frame_end_o)
  );

  assign alpha_o = bgrgba_pkg::ALPHA_OPAQUE;

endmodule
`default_nettype wire

### sv/bgrgba_ctrl.sv
// Size registers, source column and row counters and the held even-column byte.
`default_nettype none
module bgrgba_ctrl #(
  parameter int unsigned MAX_OUT_WIDTH = bgrgba_pkg::DEF_MAX_OUT_WIDTH,
  parameter int unsigned ADDR_W        = 11
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bgrgba_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  wire logic [bgrgba_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                             accept_i,
  input  wire logic [bgrgba_pkg::BYTE_W-1:0]    raw_byte_i,
  output bgrgba_pkg::item_ctrl_t                ctrl_o,
  output logic [ADDR_W-1:0]                     addr_o,
  output logic [bgrgba_pkg::PAIR_W-1:0]         wr_data_o,
  output logic [bgrgba_pkg::BYTE_W-1:0]         held_o
);

  // The 12-bit width register cannot exceed 4095, so the clamp limit is the smaller value.
  localparam int unsigned EFF_MAX = (MAX_OUT_WIDTH > 4095) ? 4095 : MAX_OUT_WIDTH;
  localparam int unsigned COL_W   = $clog2(2 * EFF_MAX);
  localparam int unsigned LCOL_W  = bgrgba_pkg::CFG_W + 1;

  logic [bgrgba_pkg::CFG_W-1:0]  width_q, height_q;
  logic [bgrgba_pkg::CFG_W-1:0]  eff_w, eff_h;
  logic [LCOL_W-1:0]             last_col;
  logic [bgrgba_pkg::ROW_W-1:0]  last_row;
  logic [COL_W-1:0]              col_q, col_d;
  logic [bgrgba_pkg::ROW_W-1:0]  row_q, row_d;
  logic [bgrgba_pkg::BYTE_W-1:0] held_q;
  logic                          at_last_col, at_last_row;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bgrgba_pkg::OUT_WIDTH_RST;
      height_q <= bgrgba_pkg::OUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bgrgba_pkg::REG_OUT_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Clamp the sizes and derive the last source column and row.
  always_comb begin
    eff_w = width_q;
    if (width_q == '0) begin
      eff_w = bgrgba_pkg::CFG_W'(1);
    end else if (width_q > bgrgba_pkg::CFG_W'(EFF_MAX)) begin
      eff_w = bgrgba_pkg::CFG_W'(EFF_MAX);
    end
    eff_h = height_q;
    if (height_q == '0) begin
      eff_h = bgrgba_pkg::CFG_W'(1);
    end else if (height_q > bgrgba_pkg::CFG_W'(bgrgba_pkg::MAX_OUT_HEIGHT)) begin
      eff_h = bgrgba_pkg::CFG_W'(bgrgba_pkg::MAX_OUT_HEIGHT);
    end
    last_col = {eff_w, 1'b0} - LCOL_W'(1);
    last_row = bgrgba_pkg::ROW_W'({eff_h, 1'b0} - LCOL_W'(1));
  end

  assign at_last_col = LCOL_W'(col_q) >= last_col;
  assign at_last_row = row_q >= last_row;

  // Raster position stepping, wrapping at row and frame end.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (at_last_col) begin
        col_d = '0;
        row_d = at_last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept_i && !col_q[0]) begin
        held_q <= raw_byte_i;
      end
    end
  end

  // Per-item decisions and line store access.
  always_comb begin
    ctrl_o.store_wr  = accept_i && col_q[0] && !row_q[0];
    ctrl_o.pix_req   = accept_i && col_q[0] && row_q[0];
    ctrl_o.frame_end = at_last_col && at_last_row;
  end

  assign addr_o    = ADDR_W'(col_q >> 1);
  assign wr_data_o = {held_q, raw_byte_i};
  assign held_o    = held_q;

endmodule
`default_nettype wire

### sv/bgrgba_line_buf.sv
// Line store holding the byte pairs of the last even source row.
`default_nettype none
module bgrgba_line_buf #(
  parameter int unsigned DEPTH  = bgrgba_pkg::DEF_MAX_OUT_WIDTH,
  parameter int unsigned ADDR_W = 11
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic                             re_i,
  input  wire logic [ADDR_W-1:0]                addr_i,
  input  wire logic [bgrgba_pkg::PAIR_W-1:0]    wr_data_i,
  output logic [bgrgba_pkg::PAIR_W-1:0]         rd_data_o
);

  logic [bgrgba_pkg::PAIR_W-1:0] mem_q [DEPTH];
  logic [bgrgba_pkg::PAIR_W-1:0] rd_q;

  // One port: a write on even rows, a registered read on odd rows.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

### sv/bgrgba_out.sv
// Pixel stage after the line store read and the output register with its handshake.
`default_nettype none
module bgrgba_out (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bgrgba_pkg::item_ctrl_t           ctrl_i,
  input  wire logic [bgrgba_pkg::BYTE_W-1:0]    raw_byte_i,
  input  wire logic [bgrgba_pkg::BYTE_W-1:0]    held_i,
  input  wire logic [bgrgba_pkg::PAIR_W-1:0]    pair_i,
  output logic                                  in_stall_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [bgrgba_pkg::BYTE_W-1:0]         red_o,
  output logic [bgrgba_pkg::BYTE_W-1:0]         green_o,
  output logic [bgrgba_pkg::BYTE_W-1:0]         blue_o,
  output logic                                  frame_end_o
);

  localparam int unsigned BW = bgrgba_pkg::BYTE_W;

  logic          s1_valid_q, out_valid_q;
  logic [BW-1:0] s1_blue_q, s1_br_q;
  logic          s1_fe_q;
  logic [BW-1:0] red_q, green_q, blue_q;
  logic          fe_q;
  logic [BW-1:0] top_left, top_right, green_d;
  logic          out_take;

  // The output register frees up when empty or when its item is taken.
  assign out_take   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_take;

  // First stage: holds the bottom row bytes while the line store read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= ctrl_i.pix_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && ctrl_i.pix_req) begin
      s1_blue_q <= held_i;
      s1_br_q   <= raw_byte_i;
      s1_fe_q   <= ctrl_i.frame_end;
    end
  end

  // Green is the sum of both halved green bytes; the sum cannot overflow.
  assign top_left  = pair_i[2*BW-1:BW];
  assign top_right = pair_i[BW-1:0];
  assign green_d   = (top_left >> 1) + (s1_br_q >> 1);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_valid_q) begin
      red_q   <= top_right;
      green_q <= green_d;
      blue_q  <= s1_blue_q;
      fe_q    <= s1_fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign frame_end_o = fe_q;

endmodule
`default_nettype wire
